FILE: rtl/rbrle_pkg.sv
// Shared types and constants for the block-repeat run-length decoder.
// Used by rbrle_segbuf, rbrle_packer and block_repeat_rle_decoder_core.
package rbrle_pkg;

    localparam int MAX_SEGMENT_DEF = 15;
    localparam int BYTE_W          = 8;
    localparam int NIB_W           = 4;
    localparam int WORD_BYTES      = 8;
    localparam int WORD_W          = WORD_BYTES * BYTE_W;
    localparam int POS_W           = $clog2(WORD_BYTES);
    localparam int CNT_W           = 4;
    localparam int TDATA_W         = ((WORD_W + CNT_W + 7) / 8) * 8;
    localparam int PAD_W           = TDATA_W - WORD_W - CNT_W;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_LITERAL,
        ST_EXPAND,
        ST_TERM
    } t_state;

    // Request from the sequencer to the packer.
    typedef struct packed {
        logic              byte_valid;
        logic              byte_last;
        logic [BYTE_W-1:0] data;
        logic              end_valid;
    } t_pack_req;

    // Packer status back to the sequencer.
    typedef struct packed {
        logic byte_ready;
        logic end_ready;
    } t_pack_stat;

endpackage

FILE: rtl/rbrle_segbuf.sv
// Segment store: holds the literal bytes of the current segment.
// Depends on rbrle_pkg for the byte width.
module rbrle_segbuf #(
    parameter int MAX_SEGMENT = rbrle_pkg::MAX_SEGMENT_DEF,
    parameter int AW          = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [rbrle_pkg::BYTE_W-1:0]   i_wdata,
    input  logic [AW-1:0]                  i_raddr,
    output logic [rbrle_pkg::BYTE_W-1:0]   o_rdata
);

    logic [rbrle_pkg::BYTE_W-1:0] r_mem [MAX_SEGMENT];
    logic [rbrle_pkg::BYTE_W-1:0] r_rdata;

    // The read address never exceeds the stored length, so it stays in range.
    // A write to the address being read is passed straight to the read register.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rbrle_packer.sv
// Packer: gathers expanded bytes into 64-bit words and holds the output register.
// Depends on rbrle_pkg for widths and the request and status structs.
module rbrle_packer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rbrle_pkg::t_pack_req            i_req,
    output rbrle_pkg::t_pack_stat           o_stat,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata fields from bit 0 up: packed_bytes[63:0], byte_count[67:64], zero fill.
    output logic [rbrle_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    // tuser fields from bit 0 up: stream_end.
    output logic                            m_axis_tuser
);

    logic [rbrle_pkg::WORD_W-1:0] r_acc;
    logic [rbrle_pkg::POS_W-1:0]  r_pos;
    logic                         r_ovalid;
    logic [rbrle_pkg::WORD_W-1:0] r_oword;
    logic [rbrle_pkg::CNT_W-1:0]  r_ocnt;
    logic                         r_olast;
    logic                         r_oend;

    logic                         out_free;
    logic                         flush;
    logic                         byte_take;
    logic                         end_take;
    logic [rbrle_pkg::WORD_W-1:0] merged;

    always_comb begin
        out_free  = !r_ovalid || m_axis_tready;
        flush     = i_req.byte_last || (r_pos == rbrle_pkg::POS_W'(rbrle_pkg::WORD_BYTES - 1));
        o_stat.byte_ready = !flush || out_free;
        o_stat.end_ready  = out_free;
        byte_take = i_req.byte_valid && o_stat.byte_ready;
        end_take  = i_req.end_valid && out_free;
        merged    = r_acc;
        merged[{r_pos, 3'b000} +: rbrle_pkg::BYTE_W] = i_req.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (byte_take) begin
                if (flush) begin
                    r_acc <= '0;
                    r_pos <= '0;
                end else begin
                    r_acc <= merged;
                    r_pos <= r_pos + 1'b1;
                end
            end
            if ((byte_take && flush) || end_take) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_take && flush) begin
            r_oword <= merged;
            r_ocnt  <= rbrle_pkg::CNT_W'(r_pos) + 1'b1;
            r_olast <= i_req.byte_last;
            r_oend  <= 1'b0;
        end else if (end_take) begin
            r_oword <= '0;
            r_ocnt  <= '0;
            r_olast <= 1'b0;
            r_oend  <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{rbrle_pkg::PAD_W{1'b0}}, r_ocnt, r_oword};
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_oend;

endmodule

FILE: rtl/block_repeat_rle_decoder_core.sv
// Block-repeat run-length decoder, top level with the header/literal/expand sequencer.
// Depends on rbrle_pkg, rbrle_segbuf and rbrle_packer.
//
// Header and literal bytes are taken without a stall. After the last literal of a
// segment the input stalls while the byte walker reads the segment store once per
// cycle, so a group with effective length L and repeat count R holds the input while
// its L*R bytes are walked (at most 225), plus any time the output side backpressures
// a full word. A zero header stalls the input until the end marker is placed in the
// output register. Results leave through a single output register, so a finished
// word can wait downstream while the walker fills the next one.
module block_repeat_rle_decoder_core #(
    parameter int MAX_SEGMENT = rbrle_pkg::MAX_SEGMENT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata fields from bit 0 up: in_byte[7:0].
    input  logic [rbrle_pkg::BYTE_W-1:0]    s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata fields from bit 0 up: packed_bytes[63:0], byte_count[67:64], zero fill.
    output logic [rbrle_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast,
    // tuser fields from bit 0 up: stream_end.
    output logic                            m_axis_tuser
);

    localparam int AW = (MAX_SEGMENT > 1) ? $clog2(MAX_SEGMENT) : 1;
    localparam logic [rbrle_pkg::NIB_W-1:0] MAX_SEG_N = rbrle_pkg::NIB_W'(MAX_SEGMENT);

    rbrle_pkg::t_state            r_state, n_state;
    logic [rbrle_pkg::NIB_W-1:0]  r_len;
    logic [rbrle_pkg::NIB_W-1:0]  r_rep;
    logic [rbrle_pkg::NIB_W-1:0]  r_taken;
    logic [rbrle_pkg::NIB_W-1:0]  r_eff;
    logic                         r_cut;
    logic [rbrle_pkg::NIB_W-1:0]  r_ptr;
    logic [rbrle_pkg::NIB_W-1:0]  n_ptr;

    rbrle_pkg::t_pack_req         pack_req;
    rbrle_pkg::t_pack_stat        pack_stat;

    logic                         in_take;
    logic                         lit_stored;
    logic                         lit_nonzero;
    logic [rbrle_pkg::NIB_W-1:0]  n_eff_lit;
    logic                         lit_last;
    logic                         go_expand;
    logic                         seg_end;
    logic                         grp_last;
    logic                         walk_take;
    logic [rbrle_pkg::BYTE_W-1:0] rd_byte;
    logic [rbrle_pkg::NIB_W-1:0]  hdr_len;
    logic [rbrle_pkg::NIB_W-1:0]  hdr_rep;

    // The store is read at the next walker position, so its registered output
    // always holds the byte at the current position.
    rbrle_segbuf #(
        .MAX_SEGMENT (MAX_SEGMENT),
        .AW          (AW)
    ) u_segbuf (
        .i_clk   (i_clk),
        .i_we    (in_take && (r_state == rbrle_pkg::ST_LITERAL) && lit_stored),
        .i_waddr (r_taken[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (n_ptr[AW-1:0]),
        .o_rdata (rd_byte)
    );

    rbrle_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (pack_req),
        .o_stat        (pack_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Datapath decode shared by next-state and register logic.
    always_comb begin
        in_take     = s_axis_tvalid && s_axis_tready;
        hdr_len     = s_axis_tdata[rbrle_pkg::BYTE_W-1 -: rbrle_pkg::NIB_W];
        hdr_rep     = s_axis_tdata[rbrle_pkg::NIB_W-1:0];
        lit_stored  = r_taken < MAX_SEG_N;
        lit_nonzero = s_axis_tdata != '0;
        // The segment is cut at its first zero literal, as a string copy would do.
        n_eff_lit   = r_eff + rbrle_pkg::NIB_W'(!r_cut && lit_stored && lit_nonzero);
        lit_last    = (r_taken + 1'b1) == r_len;
        go_expand   = (n_eff_lit != '0) && (r_rep != '0);
        seg_end     = r_ptr == (r_eff - 1'b1);
        grp_last    = seg_end && (r_rep == rbrle_pkg::NIB_W'(1));
    end

    assign walk_take = pack_req.byte_valid && pack_stat.byte_ready;

    // Next walker position.
    always_comb begin
        n_ptr = r_ptr;
        unique case (r_state)
            rbrle_pkg::ST_HEADER: n_ptr = '0;
            rbrle_pkg::ST_LITERAL: begin
                if (in_take) begin
                    n_ptr = '0;
                end
            end
            rbrle_pkg::ST_EXPAND: begin
                if (walk_take) begin
                    n_ptr = seg_end ? '0 : r_ptr + 1'b1;
                end
            end
            rbrle_pkg::ST_TERM: n_ptr = '0;
            default: n_ptr = '0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbrle_pkg::ST_HEADER: begin
                if (in_take) begin
                    if (s_axis_tdata == '0) begin
                        n_state = rbrle_pkg::ST_TERM;
                    end else if (hdr_len != '0) begin
                        n_state = rbrle_pkg::ST_LITERAL;
                    end
                end
            end
            rbrle_pkg::ST_LITERAL: begin
                if (in_take && lit_last) begin
                    n_state = go_expand ? rbrle_pkg::ST_EXPAND : rbrle_pkg::ST_HEADER;
                end
            end
            rbrle_pkg::ST_EXPAND: begin
                if (walk_take && grp_last) begin
                    n_state = rbrle_pkg::ST_HEADER;
                end
            end
            rbrle_pkg::ST_TERM: begin
                if (pack_stat.end_ready) begin
                    n_state = rbrle_pkg::ST_HEADER;
                end
            end
            default: n_state = rbrle_pkg::ST_HEADER;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_axis_tready       = 1'b0;
        pack_req.byte_valid = 1'b0;
        pack_req.byte_last  = grp_last;
        pack_req.data       = rd_byte;
        pack_req.end_valid  = 1'b0;
        unique case (r_state)
            rbrle_pkg::ST_HEADER:  s_axis_tready       = 1'b1;
            rbrle_pkg::ST_LITERAL: s_axis_tready       = 1'b1;
            rbrle_pkg::ST_EXPAND:  pack_req.byte_valid = 1'b1;
            rbrle_pkg::ST_TERM:    pack_req.end_valid  = 1'b1;
            default:               s_axis_tready       = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbrle_pkg::ST_HEADER;
            r_len   <= '0;
            r_rep   <= '0;
            r_taken <= '0;
            r_eff   <= '0;
            r_cut   <= 1'b0;
            r_ptr   <= '0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            unique case (r_state)
                rbrle_pkg::ST_HEADER: begin
                    if (in_take) begin
                        r_len   <= hdr_len;
                        r_rep   <= hdr_rep;
                        r_taken <= '0;
                        r_eff   <= '0;
                        r_cut   <= 1'b0;
                    end
                end
                rbrle_pkg::ST_LITERAL: begin
                    if (in_take) begin
                        r_taken <= r_taken + 1'b1;
                        r_eff   <= n_eff_lit;
                        r_cut   <= r_cut || (lit_stored && !lit_nonzero);
                    end
                end
                rbrle_pkg::ST_EXPAND: begin
                    // The repeat count doubles as the pass counter of the walk.
                    if (walk_take && seg_end) begin
                        r_rep <= r_rep - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: sim/tb_block_repeat_rle_decoder_core.sv
// Self-checking testbench for block_repeat_rle_decoder_core.
// Needs rbrle_pkg and the decoder RTL. A built-in predictor checks every output word.
module tb_block_repeat_rle_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SEG     = rbrle_pkg::MAX_SEGMENT_DEF;
    localparam int BYTE_W      = rbrle_pkg::BYTE_W;
    localparam int NIB_W       = rbrle_pkg::NIB_W;
    localparam int WORD_W      = rbrle_pkg::WORD_W;
    localparam int CNT_W       = rbrle_pkg::CNT_W;
    localparam int TDATA_W     = rbrle_pkg::TDATA_W;
    localparam int HOLD_CYCLES = 400;
    localparam int STUCK_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              group_done;
        logic              stream_end;
    } t_rle_word;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // Fields from bit 0 up: in_byte[7:0].
    logic [BYTE_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // Fields from bit 0 up: packed_bytes[63:0], byte_count[67:64], zero fill.
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                m_axis_tlast;
    // Fields from bit 0 up: stream_end.
    logic                m_axis_tuser;

    block_repeat_rle_decoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    logic [BYTE_W-1:0] byte_q [$];
    t_rle_word         expected_words [$];

    // Decoder state as the predictor sees it.
    logic              in_segment = 1'b0;
    logic [NIB_W-1:0]  seg_len    = '0;
    logic [NIB_W-1:0]  seg_repeat = '0;
    logic [NIB_W-1:0]  lit_count  = '0;
    logic [BYTE_W-1:0] seg_bytes [MAX_SEG];

    logic in_taken   = 1'b0;
    logic idle_on    = 1'b1;
    int   hold_asked = 0;
    int   hold_given = 0;
    int   hold_left  = 0;
    int   fail_count = 0;
    int   stuck      = 0;

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        t_rle_word w;
        int        eff;
        int        total;
        w = '0;
        if (!in_segment) begin
            if (b == 8'h00) begin
                w.stream_end = 1'b1;
                expected_words.push_back(w);
            end else begin
                seg_len    = b[7:4];
                seg_repeat = b[3:0];
                lit_count  = '0;
                in_segment = (b[7:4] != 4'h0);
            end
        end else begin
            if (lit_count < MAX_SEG)
                seg_bytes[lit_count] = b;
            lit_count = lit_count + 4'd1;
            if (lit_count == seg_len) begin
                in_segment = 1'b0;
                // The segment is cut at its first zero byte.
                eff = int'(seg_len);
                for (int i = int'(seg_len) - 1; i >= 0; i--)
                    if (seg_bytes[i] == 8'h00)
                        eff = i;
                total = eff * int'(seg_repeat);
                for (int k = 0; k < total; k++) begin
                    w.data[8*(k%8) +: 8] = seg_bytes[k % eff];
                    w.count = w.count + 4'd1;
                    if (k % 8 == 7 || k == total - 1) begin
                        w.group_done = (k == total - 1);
                        expected_words.push_back(w);
                        w = '0;
                    end
                end
            end
        end
    endtask

    // Mostly well-formed groups with random content, plus terminators, empty groups
    // and stray bytes that break the framing.
    task automatic queue_random_stream(input int target);
        int made;
        int kind;
        int len;
        int rep;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                byte_q.push_back(8'h00);
                made++;
            end else if (kind < 10) begin
                byte_q.push_back({4'h0, 4'($urandom_range(1, 15))});
                made++;
            end else if (kind < 14) begin
                byte_q.push_back(8'($urandom));
                made++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(1, 6);
                rep = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 4);
                byte_q.push_back({4'(len), 4'(rep)});
                for (int i = 0; i < len; i++)
                    byte_q.push_back(($urandom_range(0, 19) == 0) ? 8'h00
                                                                   : 8'($urandom_range(1, 255)));
                made += len + 1;
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_q.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
            @(posedge i_clk);
    endtask

    // Sender: a new byte is offered only once the previous one has been transferred.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (byte_q.size() != 0 && !(idle_on && $urandom_range(0, 99) < 15)) begin
                s_axis_tdata  <= byte_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver, with an occasional long hold-off on request.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left     <= hold_left - 1;
            end else if (hold_asked != hold_given) begin
                m_axis_tready <= 1'b0;
                hold_given    <= hold_given + 1;
                hold_left     <= HOLD_CYCLES;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 15);
            end
        end
    end

    // Input transfers feed the predictor; output transfers are checked against it.
    always @(posedge i_clk) begin
        t_rle_word want;
        if (i_rst_n) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("ERROR: unexpected word data=%h count=%0d done=%b end=%b",
                                 m_axis_tdata[WORD_W-1:0], m_axis_tdata[WORD_W +: CNT_W],
                                 m_axis_tlast, m_axis_tuser);
                end else begin
                    want = expected_words.pop_front();
                    if (m_axis_tdata[WORD_W-1:0] !== want.data
                            || m_axis_tdata[WORD_W +: CNT_W] !== want.count
                            || m_axis_tlast !== want.group_done
                            || m_axis_tuser !== want.stream_end) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"ERROR: word mismatch, expected data=%h count=%0d",
                                      " done=%b end=%b, got data=%h count=%0d done=%b end=%b"},
                                     want.data, want.count, want.group_done, want.stream_end,
                                     m_axis_tdata[WORD_W-1:0], m_axis_tdata[WORD_W +: CNT_W],
                                     m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck <= 0;
        end else if (stuck == STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        int start_size;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Terminator, empty group, zero repeat, cut segments, the longest group, then a terminator.
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h03);
        byte_q.push_back(8'h10);
        byte_q.push_back(8'h55);
        byte_q.push_back(8'h31);
        byte_q.push_back(8'h01);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h02);
        byte_q.push_back(8'h21);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'h7E);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'hFF);
        byte_q.push_back(8'h80);
        for (int i = 3; i <= 15; i++)
            byte_q.push_back(8'(i * 17 - 1));
        byte_q.push_back(8'h00);

        // The stimulus waits here until every word of the directed part is out.
        wait_drained();

        queue_random_stream(120);
        start_size = byte_q.size();
        while (start_size - byte_q.size() < 20)
            @(posedge i_clk);
        hold_asked = 1;
        while (byte_q.size() != 0)
            @(posedge i_clk);

        idle_on = 1'b0;
        queue_random_stream(65);
        while (byte_q.size() != 0)
            @(posedge i_clk);
        idle_on = 1'b1;
        queue_random_stream(65);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
